FILE: rtl/tsq_pkg.sv
package tsq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int FRAME_BITS_DEF = 24;
  localparam int IN_FRAME_W     = 24;

  localparam logic [1:0] ACT_APPEND  = 2'd0;
  localparam logic [1:0] ACT_DISCARD = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_MERGED    = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_DISCARDED = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_T_RD    = 10'b00_0000_0010,
    S_T_MUL   = 10'b00_0000_0100,
    S_T_WAIT  = 10'b00_0000_1000,
    S_NEW     = 10'b00_0001_0000,
    S_D_RD    = 10'b00_0010_0000,
    S_D_MUL   = 10'b00_0100_0000,
    S_D_WAIT  = 10'b00_1000_0000,
    S_HEAD_RD = 10'b01_0000_0000,
    S_FINISH  = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        seg_valid;
    logic [63:0] seg_start_ns;
    logic [31:0] seg_step_ns;
    logic [23:0] frame_amount;
    logic [19:0] seg_rate;
    logic [31:0] seg_stream;
    logic [63:0] seg_epoch;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entries_in_use;
    logic        head_valid;
    logic [63:0] head_start_ns;
    logic [23:0] head_frames;
    logic [23:0] frames_unconsumed;
  } out_t;

  // Entry fields other than the frame count, which is FRAME_BITS wide.
  typedef struct packed {
    logic        valid;
    logic [63:0] start;
    logic [31:0] step;
    logic [19:0] rate;
    logic [31:0] stream;
    logic [63:0] epoch;
  } entry_fix_t;

  localparam int FIX_W = $bits(entry_fix_t);

endpackage

FILE: rtl/tsq_ram.sv
module tsq_ram #(
  parameter int DEPTH = tsq_pkg::DEPTH_DEF,
  parameter int WIDTH = tsq_pkg::FIX_W + tsq_pkg::FRAME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tsq_madd.sv
module tsq_madd #(
  parameter int FRAME_BITS = tsq_pkg::FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [63:0]           addend,
  input  logic [31:0]           step,
  input  logic [FRAME_BITS-1:0] count,
  output logic                  done,
  output logic [63:0]           sum
);

  localparam int PW = 32 + FRAME_BITS;

  logic          v1;
  logic          v2;
  logic [PW-1:0] prod;
  logic [63:0]   addend_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= go;
      v2 <= v1;
    end
  end

  // multiply first, add in the following cycle
  always_ff @(posedge clk) begin
    prod     <= PW'(step) * PW'(count);
    addend_q <= addend;
    sum      <= addend_q + 64'(prod);
  end

  assign done = v2;

endmodule

FILE: rtl/timestamp_segment_queue.sv
// Bounded queue of audio timeline segments.
// Input channel in_valid/in_ready/in_data carries one request: append a
// segment, discard frames from the head, or clear. Every request yields
// exactly one result on out_valid/out_ready/out_data: a status code, the
// entry count, the head segment and the unconsumed frames after the request.
// One request is worked on at a time; in_ready is high only while idle.
// An append to a non-empty queue reads the tail entry and runs the
// multiply-add, then merges, is rejected or takes a new entry; on an empty
// queue it takes a new entry at once. A discard reads and updates each head
// entry it touches in turn. The next request is taken in the cycle after the
// result is registered. The per-entry cost comes from the entry memory (one
// write and one read port, registered read data) and the shared multiply-add
// that computes start + step * frames for both tail checks and head updates.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// entry contents are not cleared. If the receiver stalls, the result holds
// in the output register and the block waits before finishing the next one.
module timestamp_segment_queue #(
  parameter int DEPTH      = tsq_pkg::DEPTH_DEF,
  parameter int FRAME_BITS = tsq_pkg::FRAME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tsq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tsq_pkg::out_t out_data
);

  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = tsq_pkg::FIX_W + FRAME_BITS;
  localparam int AMT_W = (FRAME_BITS < tsq_pkg::IN_FRAME_W) ? FRAME_BITS
                                                            : tsq_pkg::IN_FRAME_W;

  tsq_pkg::state_t     state;
  tsq_pkg::in_t        req;
  tsq_pkg::status_t    status;
  logic [IW-1:0]       head;
  logic [CW-1:0]       count;
  logic [FRAME_BITS-1:0] rem;
  logic [FRAME_BITS-1:0] take;
  logic                tag_ok;
  logic [FRAME_BITS:0] fsum;

  logic [FRAME_BITS-1:0] frm_in;
  logic [FRAME_BITS-1:0] frm;
  logic [FRAME_BITS-1:0] take_c;
  logic [FRAME_BITS-1:0] left_frames;
  logic [FRAME_BITS-1:0] rem_after;
  logic [IW-1:0]       head_inc;
  logic [IW-1:0]       tail_slot;
  logic [IW-1:0]       new_slot;
  logic                join_ok;

  logic                ram_we;
  logic                ram_re;
  logic [IW-1:0]       ram_waddr;
  logic [IW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;
  tsq_pkg::entry_fix_t rd_fix;
  tsq_pkg::entry_fix_t wr_fix;
  logic [FRAME_BITS-1:0] rd_frames;
  logic [FRAME_BITS-1:0] wr_frames;

  logic                madd_go;
  logic                madd_done;
  logic [FRAME_BITS-1:0] madd_count;
  logic [63:0]         madd_sum;

  logic [31:0]         count32;
  logic [31:0]         rd_frames32;
  logic [31:0]         rem32;

  function automatic logic [IW-1:0] wrap_slot(input logic [IW:0] off);
    logic [IW:0] w;
    w = (off >= (IW+1)'(DEPTH)) ? off - (IW+1)'(DEPTH) : off;
    return w[IW-1:0];
  endfunction

  assign frm_in = FRAME_BITS'(in_data.frame_amount[AMT_W-1:0]);
  assign frm    = FRAME_BITS'(req.frame_amount[AMT_W-1:0]);

  assign head_inc  = (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_slot = wrap_slot({1'b0, head} + (IW+1)'(count - 1'b1));
  assign new_slot  = wrap_slot({1'b0, head} + (IW+1)'(count));

  assign rd_fix    = tsq_pkg::entry_fix_t'(ram_rdata[EW-1:FRAME_BITS]);
  assign rd_frames = ram_rdata[FRAME_BITS-1:0];

  assign take_c      = (rd_frames < rem) ? rd_frames : rem;
  assign left_frames = rd_frames - take;
  assign rem_after   = rem - take;

  assign join_ok = tag_ok && !fsum[FRAME_BITS] &&
                   (!req.seg_valid || madd_sum == req.seg_start_ns);

  assign in_ready = (state == tsq_pkg::S_IDLE);

  // shared multiply-add: tail end time on append, head advance on discard
  assign madd_go    = (state == tsq_pkg::S_T_MUL) || (state == tsq_pkg::S_D_MUL);
  assign madd_count = (state == tsq_pkg::S_T_MUL) ? rd_frames : take_c;

  tsq_madd #(
    .FRAME_BITS(FRAME_BITS)
  ) u_madd (
    .clk    (clk),
    .rst    (rst),
    .go     (madd_go),
    .addend (rd_fix.start),
    .step   (rd_fix.step),
    .count  (madd_count),
    .done   (madd_done),
    .sum    (madd_sum)
  );

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = head;
    ram_we    = 1'b0;
    ram_waddr = head;
    wr_fix    = rd_fix;
    wr_frames = rd_frames;
    unique case (state)
      tsq_pkg::S_T_RD: begin
        ram_re    = 1'b1;
        ram_raddr = tail_slot;
      end
      tsq_pkg::S_D_RD, tsq_pkg::S_HEAD_RD: begin
        ram_re = 1'b1;
      end
      tsq_pkg::S_T_WAIT: begin
        ram_we    = madd_done && join_ok;
        ram_waddr = tail_slot;
        wr_frames = fsum[FRAME_BITS-1:0];
      end
      tsq_pkg::S_NEW: begin
        ram_we        = 1'b1;
        ram_waddr     = new_slot;
        wr_fix.valid  = req.seg_valid;
        wr_fix.start  = req.seg_start_ns;
        wr_fix.step   = req.seg_step_ns;
        wr_fix.rate   = req.seg_rate;
        wr_fix.stream = req.seg_stream;
        wr_fix.epoch  = req.seg_epoch;
        wr_frames     = frm;
      end
      tsq_pkg::S_D_WAIT: begin
        ram_we = madd_done;
        if (rd_fix.valid && rd_fix.step != '0) begin
          wr_fix.start = madd_sum;
        end
        wr_frames = left_frames;
      end
      default: begin
      end
    endcase
  end

  assign ram_wdata = {wr_fix, wr_frames};

  tsq_ram #(
    .DEPTH(DEPTH),
    .WIDTH(EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsq_pkg::S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != tsq_pkg::S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        tsq_pkg::S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            rem <= (in_data.action == tsq_pkg::ACT_DISCARD) ? frm_in : '0;
            unique case (in_data.action)
              tsq_pkg::ACT_APPEND: begin
                if (frm_in == '0) begin
                  status <= tsq_pkg::ST_IGNORED;
                  state  <= tsq_pkg::S_HEAD_RD;
                end else if (count != '0) begin
                  state <= tsq_pkg::S_T_RD;
                end else begin
                  state <= tsq_pkg::S_NEW;
                end
              end
              tsq_pkg::ACT_DISCARD: begin
                status <= tsq_pkg::ST_DISCARDED;
                if (frm_in == '0 || count == '0) begin
                  state <= tsq_pkg::S_HEAD_RD;
                end else begin
                  state <= tsq_pkg::S_D_RD;
                end
              end
              tsq_pkg::ACT_CLEAR: begin
                head   <= '0;
                count  <= '0;
                status <= tsq_pkg::ST_CLEARED;
                state  <= tsq_pkg::S_HEAD_RD;
              end
              default: begin
                status <= tsq_pkg::ST_IGNORED;
                state  <= tsq_pkg::S_HEAD_RD;
              end
            endcase
          end
        end
        tsq_pkg::S_T_RD: begin
          state <= tsq_pkg::S_T_MUL;
        end
        tsq_pkg::S_T_MUL: begin
          // tag checks now, contiguity once the multiply-add finishes
          tag_ok <= rd_frames != '0 && rd_fix.valid == req.seg_valid &&
                    rd_fix.stream == req.seg_stream && rd_fix.epoch == req.seg_epoch &&
                    rd_fix.rate == req.seg_rate &&
                    (!req.seg_valid ||
                     (rd_fix.step != '0 && rd_fix.step == req.seg_step_ns));
          fsum  <= {1'b0, rd_frames} + {1'b0, frm};
          state <= tsq_pkg::S_T_WAIT;
        end
        tsq_pkg::S_T_WAIT: begin
          if (madd_done) begin
            if (join_ok) begin
              status <= tsq_pkg::ST_MERGED;
              state  <= tsq_pkg::S_HEAD_RD;
            end else if (count == CW'(DEPTH)) begin
              status <= tsq_pkg::ST_REJECTED;
              state  <= tsq_pkg::S_HEAD_RD;
            end else begin
              state <= tsq_pkg::S_NEW;
            end
          end
        end
        tsq_pkg::S_NEW: begin
          count  <= count + 1'b1;
          status <= tsq_pkg::ST_NEW;
          state  <= tsq_pkg::S_HEAD_RD;
        end
        tsq_pkg::S_D_RD: begin
          state <= tsq_pkg::S_D_MUL;
        end
        tsq_pkg::S_D_MUL: begin
          take  <= take_c;
          state <= tsq_pkg::S_D_WAIT;
        end
        tsq_pkg::S_D_WAIT: begin
          if (madd_done) begin
            rem <= rem_after;
            if (left_frames == '0) begin
              head  <= head_inc;
              count <= count - 1'b1;
            end
            // advance to the next head only when this one emptied
            if (rem_after == '0 || count == CW'(1)) begin
              state <= tsq_pkg::S_HEAD_RD;
            end else begin
              state <= tsq_pkg::S_D_RD;
            end
          end
        end
        tsq_pkg::S_HEAD_RD: begin
          state <= tsq_pkg::S_FINISH;
        end
        tsq_pkg::S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= tsq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= tsq_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign count32     = 32'(count);
  assign rd_frames32 = 32'(rd_frames);
  assign rem32       = 32'(rem);

  always_ff @(posedge clk) begin
    if (state == tsq_pkg::S_FINISH && (!out_valid || out_ready)) begin
      out_data.status            <= status;
      out_data.entries_in_use    <= count32[4:0];
      out_data.frames_unconsumed <= rem32[23:0];
      if (count != '0) begin
        out_data.head_valid    <= rd_fix.valid;
        out_data.head_start_ns <= rd_fix.start;
        out_data.head_frames   <= rd_frames32[23:0];
      end else begin
        out_data.head_valid    <= 1'b0;
        out_data.head_start_ns <= '0;
        out_data.head_frames   <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_madd_in_wait: assert property (@(posedge clk) disable iff (rst)
    madd_done |-> (state == tsq_pkg::S_T_WAIT || state == tsq_pkg::S_D_WAIT))
    else $error("multiply-add result outside a wait state");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.action == tsq_pkg::ACT_CLEAR)
      |=> (count == '0 && head == '0))
    else $error("clear left entries");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tsq_pkg::S_FINISH))
    else $error("result raised outside finish");

  a_merge_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == tsq_pkg::S_T_WAIT && madd_done && join_ok) |=> $stable(count))
    else $error("merge changed entry count");

endmodule

FILE: bench/segment_queue_checker.sv
module segment_queue_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  tsq_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  tsq_pkg::out_t out_data,
  output int            failures,
  output int            pending,
  output int            requests,
  output int            merges,
  output int            rejects
);

  localparam int SLOTS = tsq_pkg::DEPTH_DEF;
  localparam logic [23:0] FRAME_MAX = 24'((1 << tsq_pkg::FRAME_BITS_DEF) - 1);

  typedef struct packed {
    logic        valid;
    logic [63:0] start;
    logic [31:0] step;
    logic [23:0] frames;
    logic [19:0] rate;
    logic [31:0] stream;
    logic [63:0] epoch;
  } segment_t;

  segment_t      seg_ring [SLOTS];
  int            head_slot;
  int            held;
  tsq_pkg::out_t result_fifo [$];

  // A new segment extends the tail only when tags match and, for timed
  // segments, the step agrees and the times line up.
  function automatic bit extends_tail(segment_t t, tsq_pkg::in_t req);
    logic [63:0] reach;
    if (t.frames == 0 || t.valid != req.seg_valid || t.stream != req.seg_stream ||
        t.epoch != req.seg_epoch || t.rate != req.seg_rate)
      return 1'b0;
    if (!t.valid)
      return 1'b1;
    if (t.step == 0 || t.step != req.seg_step_ns)
      return 1'b0;
    reach = t.start + 64'(t.step) * 64'(t.frames);
    return reach == req.seg_start_ns;
  endfunction

  function automatic tsq_pkg::out_t apply_request(tsq_pkg::in_t req);
    tsq_pkg::out_t res;
    logic [23:0]   amount;
    logic [23:0]   left;
    logic [23:0]   take;
    int            tail;
    int            slot;
    bit            joined;
    res    = '0;
    amount = req.frame_amount & FRAME_MAX;
    left   = '0;
    joined = 1'b0;
    case (req.action)
      tsq_pkg::ACT_APPEND: begin
        if (amount == 0) begin
          res.status = tsq_pkg::ST_IGNORED;
        end else begin
          if (held > 0) begin
            tail = (head_slot + held - 1) % SLOTS;
            if (extends_tail(seg_ring[tail], req) &&
                {1'b0, seg_ring[tail].frames} + amount <= FRAME_MAX) begin
              seg_ring[tail].frames = seg_ring[tail].frames + amount;
              res.status = tsq_pkg::ST_MERGED;
              joined = 1'b1;
            end
          end
          if (!joined) begin
            if (held >= SLOTS) begin
              res.status = tsq_pkg::ST_REJECTED;
            end else begin
              slot = (head_slot + held) % SLOTS;
              seg_ring[slot].valid  = req.seg_valid;
              seg_ring[slot].start  = req.seg_start_ns;
              seg_ring[slot].step   = req.seg_step_ns;
              seg_ring[slot].frames = amount;
              seg_ring[slot].rate   = req.seg_rate;
              seg_ring[slot].stream = req.seg_stream;
              seg_ring[slot].epoch  = req.seg_epoch;
              held = held + 1;
              res.status = tsq_pkg::ST_NEW;
            end
          end
        end
      end
      tsq_pkg::ACT_DISCARD: begin
        left = amount;
        while (left != 0 && held > 0) begin
          take = (seg_ring[head_slot].frames < left) ? seg_ring[head_slot].frames : left;
          // untimed or zero-step heads keep their start
          if (seg_ring[head_slot].valid && seg_ring[head_slot].step != 0)
            seg_ring[head_slot].start = seg_ring[head_slot].start +
                                        64'(seg_ring[head_slot].step) * 64'(take);
          seg_ring[head_slot].frames = seg_ring[head_slot].frames - take;
          left = left - take;
          if (seg_ring[head_slot].frames == 0) begin
            head_slot = (head_slot + 1) % SLOTS;
            held = held - 1;
          end
        end
        res.status = tsq_pkg::ST_DISCARDED;
      end
      tsq_pkg::ACT_CLEAR: begin
        head_slot  = 0;
        held       = 0;
        res.status = tsq_pkg::ST_CLEARED;
      end
      default: begin
        res.status = tsq_pkg::ST_IGNORED;
      end
    endcase
    res.entries_in_use = 5'(held);
    if (held > 0) begin
      res.head_valid    = seg_ring[head_slot].valid;
      res.head_start_ns = seg_ring[head_slot].start;
      res.head_frames   = seg_ring[head_slot].frames;
    end
    res.frames_unconsumed = left;
    return res;
  endfunction

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
    failures = failures + 1;
  endtask

  always @(posedge clk) begin
    tsq_pkg::out_t want;
    if (rst) begin
      head_slot = 0;
      held      = 0;
      result_fifo.delete();
    end else begin
      // retire the result first: it can never belong to a request taken this edge
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          report("result with nothing pending", '0, 64'(out_data.status));
        end else begin
          want = result_fifo.pop_front();
          if (out_data.status !== want.status)
            report("status", 64'(want.status), 64'(out_data.status));
          if (out_data.entries_in_use !== want.entries_in_use)
            report("entries_in_use", 64'(want.entries_in_use), 64'(out_data.entries_in_use));
          if (out_data.head_valid !== want.head_valid)
            report("head_valid", 64'(want.head_valid), 64'(out_data.head_valid));
          if (out_data.head_start_ns !== want.head_start_ns)
            report("head_start_ns", want.head_start_ns, out_data.head_start_ns);
          if (out_data.head_frames !== want.head_frames)
            report("head_frames", 64'(want.head_frames), 64'(out_data.head_frames));
          if (out_data.frames_unconsumed !== want.frames_unconsumed)
            report("frames_unconsumed", 64'(want.frames_unconsumed),
                   64'(out_data.frames_unconsumed));
        end
      end
      if (in_valid && in_ready) begin
        want = apply_request(in_data);
        result_fifo.insert(result_fifo.size(), want);
        requests = requests + 1;
        if (want.status == tsq_pkg::ST_MERGED)
          merges = merges + 1;
        if (want.status == tsq_pkg::ST_REJECTED)
          rejects = rejects + 1;
      end
    end
    pending = result_fifo.size();
  end

endmodule

FILE: bench/timestamp_segment_queue_test.sv
module timestamp_segment_queue_test;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int TARGET_REQUESTS = 1000;
  localparam int CALM_TAIL       = 150;
  localparam int HOLD_CYCLES     = 400;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  tsq_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  tsq_pkg::out_t out_data;

  int failures;
  int pending;
  int requests;
  int merges;
  int rejects;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  // current chain of appended segments
  logic        ctx_valid;
  logic [63:0] ctx_next;
  logic [31:0] ctx_step;
  logic [19:0] ctx_rate;
  logic [31:0] ctx_stream;
  logic [63:0] ctx_epoch;

  logic [31:0] stream_pool [4];
  logic [63:0] epoch_pool  [4];
  logic [19:0] rate_pool   [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timestamp_segment_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  segment_queue_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .failures  (failures),
    .pending   (pending),
    .requests  (requests),
    .merges    (merges),
    .rejects   (rejects)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic tsq_pkg::in_t seg_req(logic valid, logic [63:0] start,
                                           logic [31:0] step, logic [23:0] frames,
                                           logic [19:0] rate, logic [31:0] stream,
                                           logic [63:0] epoch);
    tsq_pkg::in_t r;
    r.action       = tsq_pkg::ACT_APPEND;
    r.seg_valid    = valid;
    r.seg_start_ns = start;
    r.seg_step_ns  = step;
    r.frame_amount = frames;
    r.seg_rate     = rate;
    r.seg_stream   = stream;
    r.seg_epoch    = epoch;
    return r;
  endfunction

  function automatic tsq_pkg::in_t ctrl_req(logic [1:0] action, logic [23:0] frames);
    tsq_pkg::in_t r;
    r              = '0;
    r.action       = action;
    r.frame_amount = frames;
    return r;
  endfunction

  function automatic void new_context();
    int roll;
    roll       = $urandom_range(0, 9);
    ctx_valid  = ($urandom_range(0, 5) != 0);
    ctx_step   = (roll == 0) ? 32'd0 : (roll == 1) ? $urandom : $urandom_range(1, 50000);
    ctx_next   = rand64();
    ctx_stream = stream_pool[$urandom_range(0, 3)];
    ctx_epoch  = epoch_pool[$urandom_range(0, 3)];
    ctx_rate   = rate_pool[$urandom_range(0, 3)];
  endfunction

  // Append the next piece of the current chain; modest keeps it small.
  function automatic tsq_pkg::in_t chain_append(bit contiguous, bit modest);
    tsq_pkg::in_t r;
    logic [23:0]  frames;
    int           roll;
    roll = $urandom_range(0, 99);
    if (modest || roll < 70)
      frames = 24'($urandom_range(1, 400));
    else if (roll < 82)
      frames = 24'($urandom);
    else if (roll < 88)
      frames = 24'hFF_FFFF;
    else if (roll < 94)
      frames = 24'h80_0000 | 24'($urandom_range(0, 4095));
    else
      frames = '0;
    r = seg_req(ctx_valid, contiguous ? ctx_next : rand64(), ctx_step, frames,
                ctx_rate, ctx_stream, ctx_epoch);
    ctx_next = r.seg_start_ns + 64'(ctx_step) * 64'(frames);
    return r;
  endfunction

  function automatic tsq_pkg::in_t random_request();
    tsq_pkg::in_t r;
    int           roll;
    int           pick;
    r    = '0;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      if ($urandom_range(0, 9) == 0)
        new_context();
      r = chain_append($urandom_range(0, 6) != 0, 1'b0);
    end else if (roll < 86) begin
      pick = $urandom_range(0, 9);
      r.action = tsq_pkg::ACT_DISCARD;
      r.frame_amount = (pick == 0) ? 24'd0 :
                       (pick < 7)  ? 24'($urandom_range(1, 600)) :
                       (pick < 9)  ? 24'($urandom_range(1, 5000)) : 24'($urandom);
    end else if (roll < 91) begin
      r.action = tsq_pkg::ACT_CLEAR;
    end else begin
      // noise: every field random, any action code
      r.action       = 2'($urandom);
      r.seg_valid    = 1'($urandom);
      r.seg_start_ns = rand64();
      r.seg_step_ns  = $urandom;
      r.frame_amount = 24'($urandom);
      r.seg_rate     = 20'($urandom);
      r.seg_stream   = $urandom;
      r.seg_epoch    = rand64();
    end
    return r;
  endfunction

  task automatic push_request(tsq_pkg::in_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_counted(tsq_pkg::in_t req, inout int counted);
    push_request(req);
    if (!(req.action == ACT_UNUSED ||
          (req.action == tsq_pkg::ACT_APPEND && req.frame_amount == 0)))
      counted = counted + 1;
    sender_gap();
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timestamp_segment_queue_test failed");
    $finish;
  end

  initial begin
    logic [63:0] s0;
    int          counted;
    int          kind;
    bit          did_hold;
    bit          did_drain;
    counted   = 0;
    did_hold  = 1'b0;
    did_drain = 1'b0;
    for (int i = 0; i < 4; i++) begin
      stream_pool[i] = $urandom;
      epoch_pool[i]  = rand64();
      rate_pool[i]   = 20'($urandom);
    end
    new_context();
    s0 = 64'h0000_0100_0000_0000;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    push_request(ctrl_req(tsq_pkg::ACT_CLEAR, 24'd0));
    push_request(ctrl_req(ACT_UNUSED, 24'hFF_FFFF));
    push_request(ctrl_req(tsq_pkg::ACT_DISCARD, 24'd5));
    push_request(seg_req(1'b1, s0, 32'd1000, 24'd0, 20'd48000, 32'd1, 64'd1));
    push_request(seg_req(1'b1, s0, 32'd1000, 24'd10, 20'd48000, 32'd1, 64'd1));
    push_request(seg_req(1'b1, s0 + 64'd10000, 32'd1000, 24'd5, 20'd48000, 32'd1, 64'd1));
    push_request(seg_req(1'b1, s0 + 64'd15001, 32'd1000, 24'd5, 20'd48000, 32'd1, 64'd1));
    push_request(seg_req(1'b0, rand64(), 32'd7, 24'd3, 20'd44100, 32'd2, 64'd2));
    push_request(seg_req(1'b0, rand64(), 32'd9, 24'd4, 20'd44100, 32'd2, 64'd2));
    push_request(seg_req(1'b1, 64'd5, 32'd0, 24'd6, 20'd44100, 32'd3, 64'd3));
    push_request(seg_req(1'b1, 64'd5, 32'd0, 24'd6, 20'd44100, 32'd3, 64'd3));
    push_request(seg_req(1'b1, 64'd0, 32'd1, 24'hFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF,
                         64'hFFFF_FFFF_FFFF_FFFF));
    // contiguous, but the merged count would not fit
    push_request(seg_req(1'b1, 64'h00FF_FFFF, 32'd1, 24'd1, 20'hF_FFFF, 32'hFFFF_FFFF,
                         64'hFFFF_FFFF_FFFF_FFFF));
    push_request(ctrl_req(tsq_pkg::ACT_DISCARD, 24'd0));
    push_request(seg_req(1'b1, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 24'd100, 20'd0,
                         32'd0, 64'd0));
    push_request(ctrl_req(tsq_pkg::ACT_DISCARD, 24'hFF_FFFF));
    push_request(ctrl_req(tsq_pkg::ACT_DISCARD, 24'd40));
    // start of the head wraps past 2^64
    push_request(ctrl_req(tsq_pkg::ACT_DISCARD, 24'd50));
    push_request(ctrl_req(tsq_pkg::ACT_DISCARD, 24'hFF_FFFF));

    // random episodes
    while (counted < TARGET_REQUESTS) begin
      if (!calm && counted >= TARGET_REQUESTS - CALM_TAIL)
        calm = 1'b1;
      if (!did_hold && counted >= 300) begin
        did_hold = 1'b1;
        hold_req = 1'b1;
      end
      if (!did_drain && counted >= 600) begin
        did_drain = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // fresh segments past the depth: fills the queue and hits rejection
        repeat (20) begin
          new_context();
          send_counted(chain_append(1'b1, 1'b1), counted);
        end
      end else begin
        repeat ($urandom_range(5, 30))
          send_counted(random_request(), counted);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
    $display("run covered %0d requests, %0d merged appends, %0d appends refused on a full queue",
             requests, merges, rejects);
    if (failures == 0 && pending == 0)
      $display("timestamp_segment_queue_test passed");
    else
      $display("timestamp_segment_queue_test failed");
    $finish;
  end

endmodule
